// ===== sv/sfta_pkg.sv =====
package sfta_pkg;

    typedef struct packed {
        logic signed [15:0] tex_t;
        logic signed [15:0] tex_s;
        logic signed [15:0] normal_index;
        logic signed [15:0] vertex_index;
    } vertex_t;

    // one queued item: a whole triangle in emit order, or an end marker
    typedef struct packed {
        logic    end_mark;
        vertex_t c2;
        vertex_t c1;
        vertex_t c0;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } push_t;

    typedef enum logic [2:0] {
        PH_CMD,
        PH_VIDX,
        PH_NIDX,
        PH_S,
        PH_T
    } phase_t;

    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_MID   = 2'd1;
    localparam logic [1:0] CORNER_LAST  = 2'd2;

    // vertex count within a primitive, saturating
    localparam logic [1:0] VCNT_NONE = 2'd0;
    localparam logic [1:0] VCNT_ONE  = 2'd1;
    localparam logic [1:0] VCNT_MANY = 2'd2;

endpackage

// ===== sv/sfta_front.sv =====
module sfta_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic signed [15:0]     s_stream_word,
    input  logic                   q_full,
    input  logic                   cfg_valid,
    input  logic                   cfg_data,
    output sfta_pkg::push_t        push_out
);

    sfta_pkg::phase_t  phase_reg, phase_next;
    logic [15:0]       left_reg, left_next;
    logic              strip_reg, strip_next;
    logic [1:0]        vcnt_reg, vcnt_next;
    logic              odd_reg, odd_next;
    logic              flip_reg;
    sfta_pkg::vertex_t pivot_reg, pivot_next;
    sfta_pkg::vertex_t older_reg, older_next;
    sfta_pkg::vertex_t newer_reg, newer_next;
    sfta_pkg::vertex_t part_reg, part_next;
    sfta_pkg::vertex_t cur;
    logic [15:0]       wu;
    logic              accept;
    logic              rev;

    assign wu     = s_stream_word;
    assign accept = s_valid && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sfta_pkg::PH_CMD;
            left_reg  <= '0;
            strip_reg <= 1'b0;
            vcnt_reg  <= sfta_pkg::VCNT_NONE;
            odd_reg   <= 1'b0;
            flip_reg  <= 1'b1;
        end else begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            strip_reg <= strip_next;
            vcnt_reg  <= vcnt_next;
            odd_reg   <= odd_next;
            if (cfg_valid) begin
                flip_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pivot_reg <= pivot_next;
        older_reg <= older_next;
        newer_reg <= newer_next;
        part_reg  <= part_next;
    end

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        strip_next = strip_reg;
        vcnt_next  = vcnt_reg;
        odd_next   = odd_reg;
        pivot_next = pivot_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        part_next  = part_reg;
        push_out   = '0;
        cur        = part_reg;
        cur.tex_t  = s_stream_word;
        rev        = 1'b0;
        if (accept) begin
            unique case (phase_reg)
                sfta_pkg::PH_CMD: begin
                    if (wu == 16'd0) begin
                        push_out.push         = 1'b1;
                        push_out.job.end_mark = 1'b1;
                    end else begin
                        strip_next = !wu[15];
                        left_next  = wu[15] ? (16'd0 - wu) : wu;
                        vcnt_next  = sfta_pkg::VCNT_NONE;
                        odd_next   = 1'b0;
                        phase_next = sfta_pkg::PH_VIDX;
                    end
                end
                sfta_pkg::PH_VIDX: begin
                    part_next.vertex_index = s_stream_word;
                    phase_next             = sfta_pkg::PH_NIDX;
                end
                sfta_pkg::PH_NIDX: begin
                    part_next.normal_index = s_stream_word;
                    phase_next             = sfta_pkg::PH_S;
                end
                sfta_pkg::PH_S: begin
                    part_next.tex_s = s_stream_word;
                    phase_next      = sfta_pkg::PH_T;
                end
                sfta_pkg::PH_T: begin
                    priority if (vcnt_reg == sfta_pkg::VCNT_NONE) begin
                        pivot_next = cur;
                        older_next = cur;
                        newer_next = cur;
                        vcnt_next  = sfta_pkg::VCNT_ONE;
                    end else if (vcnt_reg == sfta_pkg::VCNT_ONE) begin
                        newer_next = cur;
                        vcnt_next  = sfta_pkg::VCNT_MANY;
                    end else begin
                        rev                   = strip_reg ? (odd_reg ^ flip_reg) : flip_reg;
                        push_out.push         = 1'b1;
                        push_out.job.end_mark = 1'b0;
                        push_out.job.c0       = strip_reg ? older_reg : pivot_reg;
                        push_out.job.c1       = rev ? cur : newer_reg;
                        push_out.job.c2       = rev ? newer_reg : cur;
                        older_next            = newer_reg;
                        newer_next            = cur;
                    end
                    odd_next   = !odd_reg;
                    left_next  = left_reg - 16'd1;
                    phase_next = (left_reg == 16'd1) ? sfta_pkg::PH_CMD : sfta_pkg::PH_VIDX;
                end
                default: begin
                    phase_next = sfta_pkg::PH_CMD;
                end
            endcase
        end
    end

endmodule

// ===== sv/sfta_queue.sv =====
module sfta_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sfta_pkg::push_t      push_in,
    input  logic                 pop,
    output logic                 full,
    output logic                 q_valid,
    output sfta_pkg::job_t       head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sfta_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push_in.push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_in.job;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

endmodule

// ===== sv/sfta_back.sv =====
module sfta_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  sfta_pkg::job_t       head,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_vertex_index,
    output logic signed [15:0]   m_normal_index,
    output logic signed [15:0]   m_tex_s,
    output logic signed [15:0]   m_tex_t,
    output logic [1:0]           m_corner,
    output logic                 m_triangle_last,
    output logic                 m_stream_end
);

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        corner_reg, corner_next;
    sfta_pkg::vertex_t vtx_reg, vtx_next;
    logic [1:0]        ocorner_reg, ocorner_next;
    logic              last_reg, last_next;
    logic              end_reg, end_next;
    sfta_pkg::vertex_t sel;
    logic              load;

    assign load = (!m_valid_reg || m_ready) && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            corner_reg  <= sfta_pkg::CORNER_FIRST;
        end else begin
            m_valid_reg <= m_valid_next;
            corner_reg  <= corner_next;
        end
    end

    always_ff @(posedge aclk) begin
        vtx_reg     <= vtx_next;
        ocorner_reg <= ocorner_next;
        last_reg    <= last_next;
        end_reg     <= end_next;
    end

    always_comb begin
        unique case (corner_reg)
            sfta_pkg::CORNER_FIRST: sel = head.c0;
            sfta_pkg::CORNER_MID:   sel = head.c1;
            default:                sel = head.c2;
        endcase
    end

    always_comb begin
        m_valid_next = (m_valid_reg && !m_ready) || q_valid;
        corner_next  = corner_reg;
        vtx_next     = vtx_reg;
        ocorner_next = ocorner_reg;
        last_next    = last_reg;
        end_next     = end_reg;
        pop          = 1'b0;
        if (load) begin
            if (head.end_mark) begin
                vtx_next     = '0;
                ocorner_next = sfta_pkg::CORNER_FIRST;
                last_next    = 1'b0;
                end_next     = 1'b1;
                pop          = 1'b1;
                corner_next  = sfta_pkg::CORNER_FIRST;
            end else begin
                vtx_next     = sel;
                ocorner_next = corner_reg;
                last_next    = (corner_reg == sfta_pkg::CORNER_LAST);
                end_next     = 1'b0;
                if (corner_reg == sfta_pkg::CORNER_LAST) begin
                    pop         = 1'b1;
                    corner_next = sfta_pkg::CORNER_FIRST;
                end else begin
                    corner_next = corner_reg + 2'd1;
                end
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_vertex_index  = vtx_reg.vertex_index;
    assign m_normal_index  = vtx_reg.normal_index;
    assign m_tex_s         = vtx_reg.tex_s;
    assign m_tex_t         = vtx_reg.tex_t;
    assign m_corner        = ocorner_reg;
    assign m_triangle_last = last_reg;
    assign m_stream_end    = end_reg;

endmodule

// ===== sv/strip_fan_triangle_assembly_unit.sv =====
// Path: the t word of a triangle's closing vertex pushes the triangle into the
//   QUEUE_DEPTH-entry queue, from which the output sequencer takes its corners in turn.
// Throughput: one stream word per cycle unless the queue is full; the output sequencer
//   emits one corner per cycle unless m_ready stalls it, three per triangle.
// Reset: synchronous, active low; parser expects a command word, queue and output
//   register empty, flip_winding set to 1.
module strip_fan_triangle_assembly_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [15:0]   s_stream_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_vertex_index,
    output logic signed [15:0]   m_normal_index,
    output logic signed [15:0]   m_tex_s,
    output logic signed [15:0]   m_tex_t,
    output logic [1:0]           m_corner,
    output logic                 m_triangle_last,
    output logic                 m_stream_end,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    sfta_pkg::push_t push_w;
    sfta_pkg::job_t  head_w;
    logic            full_w;
    logic            q_valid_w;
    logic            pop_w;

    assign s_ready   = !full_w;
    assign cfg_ready = 1'b1;

    sfta_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_stream_word (s_stream_word),
        .q_full        (full_w),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .push_out      (push_w)
    );

    sfta_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_in (push_w),
        .pop     (pop_w),
        .full    (full_w),
        .q_valid (q_valid_w),
        .head    (head_w)
    );

    sfta_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid_w),
        .head            (head_w),
        .pop             (pop_w),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_vertex_index  (m_vertex_index),
        .m_normal_index  (m_normal_index),
        .m_tex_s         (m_tex_s),
        .m_tex_t         (m_tex_t),
        .m_corner        (m_corner),
        .m_triangle_last (m_triangle_last),
        .m_stream_end    (m_stream_end)
    );

endmodule

// ===== sv/sfta_checker.sv =====
module sfta_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic signed [15:0]  m_vertex_index,
    input logic signed [15:0]  m_normal_index,
    input logic signed [15:0]  m_tex_s,
    input logic signed [15:0]  m_tex_t,
    input logic [1:0]          m_corner,
    input logic                m_triangle_last,
    input logic                m_stream_end
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vertex_index) && $stable(m_corner)
            && $stable(m_stream_end))
        else $error("result item changed while stalled");

    a_end_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_end |-> m_corner == 2'd0 && !m_triangle_last
            && m_vertex_index == 16'sd0 && m_normal_index == 16'sd0
            && m_tex_s == 16'sd0 && m_tex_t == 16'sd0)
        else $error("end marker carries non-zero fields");

    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_stream_end |-> m_corner != 2'd3 && (m_triangle_last == (m_corner == 2'd2)))
        else $error("corner and triangle_last disagree");

    a_corner_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_stream_end && (m_corner == 2'd0 || m_corner == 2'd1)
            |=> m_valid && !m_stream_end && m_corner == $past(m_corner) + 2'd1)
        else $error("triangle corners not emitted back to back");

endmodule

bind strip_fan_triangle_assembly_unit sfta_checker u_sfta_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_vertex_index  (m_vertex_index),
    .m_normal_index  (m_normal_index),
    .m_tex_s         (m_tex_s),
    .m_tex_t         (m_tex_t),
    .m_corner        (m_corner),
    .m_triangle_last (m_triangle_last),
    .m_stream_end    (m_stream_end)
);

// ===== tb/strip_fan_checker.sv =====
`timescale 1ns / 100ps

module strip_fan_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [15:0] s_stream_word,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_vertex_index,
    input  logic [15:0] m_normal_index,
    input  logic [15:0] m_tex_s,
    input  logic [15:0] m_tex_t,
    input  logic [1:0]  m_corner,
    input  logic        m_triangle_last,
    input  logic        m_stream_end,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        sfta_pkg::vertex_t vtx;
        logic [1:0]        corner;
        logic              last;
        logic              end_mark;
    } corner_rec_t;

    corner_rec_t        corner_q[$];

    logic               flip;
    sfta_pkg::phase_t   phase;
    logic [16:0]        verts_left;
    logic               strip;
    logic [15:0]        vert_num;
    sfta_pkg::vertex_t  pivot;
    sfta_pkg::vertex_t  older;
    sfta_pkg::vertex_t  newer;
    sfta_pkg::vertex_t  part;

    function automatic string fmt(corner_rec_t r);
        return $sformatf("idx %0d nrm %0d s %0d t %0d corner %0d last %b end %b",
                         $signed(r.vtx.vertex_index), $signed(r.vtx.normal_index),
                         $signed(r.vtx.tex_s), $signed(r.vtx.tex_t),
                         r.corner, r.last, r.end_mark);
    endfunction

    task automatic queue_corner(input corner_rec_t r);
        corner_q.insert(corner_q.size(), r);
    endtask

    task automatic push_triangle(input sfta_pkg::vertex_t a, input sfta_pkg::vertex_t b,
                                 input sfta_pkg::vertex_t c, input logic rev);
        queue_corner('{vtx: a, corner: sfta_pkg::CORNER_FIRST, last: 1'b0,
                       end_mark: 1'b0});
        queue_corner('{vtx: rev ? c : b, corner: sfta_pkg::CORNER_MID, last: 1'b0,
                       end_mark: 1'b0});
        queue_corner('{vtx: rev ? b : c, corner: sfta_pkg::CORNER_LAST, last: 1'b1,
                       end_mark: 1'b0});
    endtask

    task automatic assemble_word(input logic [15:0] w);
        sfta_pkg::vertex_t cur;
        case (phase)
            sfta_pkg::PH_VIDX: begin
                part.vertex_index = w;
                phase = sfta_pkg::PH_NIDX;
            end
            sfta_pkg::PH_NIDX: begin
                part.normal_index = w;
                phase = sfta_pkg::PH_S;
            end
            sfta_pkg::PH_S: begin
                part.tex_s = w;
                phase = sfta_pkg::PH_T;
            end
            sfta_pkg::PH_T: begin
                cur       = part;
                cur.tex_t = w;
                part      = '0;
                if (vert_num == 16'd0) begin
                    pivot = cur;
                    older = cur;
                    newer = cur;
                end else if (vert_num == 16'd1) begin
                    newer = cur;
                end else begin
                    // strip winding alternates with vertex parity
                    if (strip)
                        push_triangle(older, newer, cur, vert_num[0] ^ flip);
                    else
                        push_triangle(pivot, newer, cur, flip);
                    older = newer;
                    newer = cur;
                end
                vert_num = vert_num + 16'd1;
                if (verts_left != 17'd0)
                    verts_left = verts_left - 17'd1;
                phase = (verts_left != 17'd0) ? sfta_pkg::PH_VIDX : sfta_pkg::PH_CMD;
            end
            default: begin
                if (w == 16'd0) begin
                    queue_corner('{vtx: '0, corner: sfta_pkg::CORNER_FIRST, last: 1'b0,
                                   end_mark: 1'b1});
                end else begin
                    strip      = ~w[15];
                    verts_left = strip ? {1'b0, w} : (17'h10000 - {1'b0, w});
                    vert_num   = '0;
                    part       = '0;
                    phase      = sfta_pkg::PH_VIDX;
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        corner_rec_t got;
        corner_rec_t want;
        if (!aresetn) begin
            flip       = 1'b1;
            phase      = sfta_pkg::PH_CMD;
            verts_left = '0;
            strip      = 1'b0;
            vert_num   = '0;
            pivot      = '0;
            older      = '0;
            newer      = '0;
            part       = '0;
            corner_q.delete();
            errors     = 0;
            pending    = 0;
        end else begin
            if (m_valid && m_ready) begin
                got.vtx.vertex_index = m_vertex_index;
                got.vtx.normal_index = m_normal_index;
                got.vtx.tex_s        = m_tex_s;
                got.vtx.tex_t        = m_tex_t;
                got.corner           = m_corner;
                got.last             = m_triangle_last;
                got.end_mark         = m_stream_end;
                if (corner_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("checker: unexpected corner: %s", fmt(got));
                end else begin
                    want = corner_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("checker: mismatch\n  expected %s\n  actual   %s",
                                     fmt(want), fmt(got));
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                flip = cfg_data;
            if (s_valid && s_ready)
                assemble_word(s_stream_word);
            pending = corner_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_stream_word = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic signed [15:0] m_vertex_index;
    logic signed [15:0] m_normal_index;
    logic signed [15:0] m_tex_s;
    logic signed [15:0] m_tex_t;
    logic [1:0]         m_corner;
    logic               m_triangle_last;
    logic               m_stream_end;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic               cfg_data      = 1'b0;

    int errors;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    strip_fan_triangle_assembly_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_stream_word   (s_stream_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_vertex_index  (m_vertex_index),
        .m_normal_index  (m_normal_index),
        .m_tex_s         (m_tex_s),
        .m_tex_t         (m_tex_t),
        .m_corner        (m_corner),
        .m_triangle_last (m_triangle_last),
        .m_stream_end    (m_stream_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    strip_fan_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_stream_word   (s_stream_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_vertex_index  (m_vertex_index),
        .m_normal_index  (m_normal_index),
        .m_tex_s         (m_tex_s),
        .m_tex_t         (m_tex_t),
        .m_corner        (m_corner),
        .m_triangle_last (m_triangle_last),
        .m_stream_end    (m_stream_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .errors          (errors),
        .pending         (pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_word(input logic [15:0] w);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_stream_word <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_vertex(input logic [15:0] idx, input logic [15:0] nrm,
                               input logic [15:0] s, input logic [15:0] t);
        send_word(idx);
        send_word(nrm);
        send_word(s);
        send_word(t);
    endtask

    // only written once the block has drained
    task automatic write_flip(input logic v);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_word();
        logic [15:0] corner_vals[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        if ($urandom_range(7) == 0)
            return corner_vals[$urandom_range(3)];
        return 16'($urandom);
    endfunction

    task automatic send_rand_vertex();
        send_vertex(rand_word(), rand_word(), rand_word(), rand_word());
    endtask

    task automatic run_primitives(input int words);
        int          sent;
        int          r;
        int          count;
        logic [15:0] cmd;
        sent = 0;
        while (sent < words) begin
            r = $urandom_range(99);
            if (r < 12)
                count = 0;
            else if (r < 20)
                count = $urandom_range(40, 9);
            else
                count = $urandom_range(6, 1);
            cmd = 16'(count);
            if ($urandom_range(1))
                cmd = -cmd;
            send_word(cmd);
            repeat (count) send_rand_vertex();
            sent += 1 + 4 * count;
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 15;
        rx_idle_pct = 59;
        write_flip(1'b0);

        // end of list, then a one-vertex fan
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_vertex(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);

        // fan of three
        send_word(16'hFFFD);
        send_vertex(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000);
        send_vertex(16'h0001, 16'h0002, 16'h0003, 16'h0004);
        send_vertex(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);

        // strip of four, winding flipped between its two triangles
        send_word(16'h0004);
        send_vertex(16'h0010, 16'h0011, 16'h0012, 16'h0013);
        send_vertex(16'h0020, 16'h0021, 16'h0022, 16'h0023);
        send_vertex(16'h0030, 16'h0031, 16'h0032, 16'h0033);
        write_flip(1'b1);
        send_vertex(16'h0040, 16'h0041, 16'h0042, 16'h0043);

        run_primitives(120);

        write_flip(1'b0);
        tx_idle_pct = 59;
        rx_idle_pct = 15;
        run_primitives(120);

        write_flip(1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_primitives(120);

        // most negative command opens a fan; the run ends inside it
        send_word(16'h8000);
        repeat (5) send_rand_vertex();

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== files.f =====
sv/sfta_pkg.sv
sv/sfta_front.sv
sv/sfta_queue.sv
sv/sfta_back.sv
sv/strip_fan_triangle_assembly_unit.sv
sv/sfta_checker.sv
tb/strip_fan_checker.sv
tb/tb_top.sv
